FILE: rtl/csrl_pkg.sv
// ----------------------------------------------------------------------------
// csrl_pkg
// Shared types and constants for the clamped slew-rate limiter.
// ----------------------------------------------------------------------------
package csrl_pkg;

   // field widths
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned StepWidth  = 31;
   localparam int unsigned OpWidth    = 2;
   localparam int unsigned CsrIdxWidth = 2;

   // operation codes carried by a request
   typedef enum logic [OpWidth-1:0] {
      OP_PROCESS = 2'd0,
      OP_LOAD    = 2'd1,
      OP_CLEAR   = 2'd2
   } csrl_op_type;

   // configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LIMIT_LOW  = 2'd0,
      CSR_LIMIT_HIGH = 2'd1,
      CSR_MIN_STEP   = 2'd2
   } csrl_csr_idx_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic signed [ValueWidth-1:0] limit_low;
      logic signed [ValueWidth-1:0] limit_high;
      logic [StepWidth-1:0]         min_step;
   } csrl_cfg_type;

   // limiter state carried from one request to the next
   typedef struct packed {
      logic signed [ValueWidth-1:0] requested;
      logic signed [ValueWidth-1:0] current;
      logic                         step_active;
   } csrl_state_type;

   // one result item
   typedef struct packed {
      logic                         processed;
      logic signed [ValueWidth-1:0] output_value;
      logic                         stepping;
      logic                         write_back;
      logic signed [ValueWidth-1:0] write_back_value;
   } csrl_result_type;

endpackage

FILE: rtl/csrl_channels.sv
// ----------------------------------------------------------------------------
// csrl_channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface csrl_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           operation;
   logic signed [31:0]   set_value;

   modport source (output valid, output operation, output set_value, input ready);
   modport sink   (input valid, input operation, input set_value, output ready);
endinterface

interface csrl_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 processed;
   logic signed [31:0]   output_value;
   logic                 stepping;
   logic                 write_back;
   logic signed [31:0]   write_back_value;

   modport source (output valid, output processed, output output_value,
                   output stepping, output write_back, output write_back_value,
                   input ready);
   modport sink   (input valid, input processed, input output_value,
                   input stepping, input write_back, input write_back_value,
                   output ready);
endinterface

FILE: rtl/csrl_cfg_regs.sv
// ----------------------------------------------------------------------------
// csrl_cfg_regs
// Configuration registers: clamp limits and largest step per request.
// ----------------------------------------------------------------------------
module csrl_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [csrl_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [csrl_pkg::ValueWidth-1:0]  csr_write_data,
   output csrl_pkg::csrl_cfg_type           cfg
);
   import csrl_pkg::*;

   logic signed [ValueWidth-1:0] limit_low_ff;
   logic signed [ValueWidth-1:0] limit_high_ff;
   logic [StepWidth-1:0]         min_step_ff;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_low_ff  <= '0;
         limit_high_ff <= '0;
         min_step_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LIMIT_LOW:  limit_low_ff  <= csr_write_data;
            CSR_LIMIT_HIGH: limit_high_ff <= csr_write_data;
            CSR_MIN_STEP:   min_step_ff   <= csr_write_data[StepWidth-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.limit_low  = limit_low_ff;
   assign cfg.limit_high = limit_high_ff;
   assign cfg.min_step   = min_step_ff;

endmodule

FILE: rtl/csrl_step_logic.sv
// ----------------------------------------------------------------------------
// csrl_step_logic
// Single-pass update: clamp the request, then step current toward it.
// ----------------------------------------------------------------------------
module csrl_step_logic (
   input  logic [csrl_pkg::OpWidth-1:0]           operation,
   input  logic signed [csrl_pkg::ValueWidth-1:0] set_value,
   input  csrl_pkg::csrl_cfg_type                 cfg,
   input  csrl_pkg::csrl_state_type               state,
   output csrl_pkg::csrl_state_type               state_next,
   output csrl_pkg::csrl_result_type              result
);
   import csrl_pkg::*;

   logic signed [ValueWidth-1:0] low;
   logic signed [ValueWidth-1:0] high;
   logic signed [ValueWidth-1:0] req_cur;
   logic signed [ValueWidth-1:0] cur;
   logic signed [ValueWidth-1:0] req_pre;
   logic signed [ValueWidth-1:0] req_clamped;
   logic signed [ValueWidth:0]   cur_ext;
   logic signed [ValueWidth:0]   req_ext;
   logic signed [ValueWidth:0]   step_ext;
   logic signed [ValueWidth:0]   moved;
   logic                         going_down;
   logic                         overshoot;
   logic signed [ValueWidth-1:0] out_val;
   logic                         step_out;
   logic                         idle_match;

   assign low     = cfg.limit_low;
   assign high    = cfg.limit_high;
   assign req_cur = state.requested;
   assign cur     = state.current;

   // no work when the set-point already matches request and output
   assign idle_match = (set_value == req_cur) && (set_value == cur);

   // new request unless a ramp is under way, then clamp when limits are sane
   always_comb begin
      req_pre = state.step_active ? req_cur : set_value;
      req_clamped = req_pre;
      if (high > low) begin
         if (req_pre > high) begin
            req_clamped = high;
         end else if (req_pre < low) begin
            req_clamped = low;
         end
      end
   end

   // step current toward the request by at most min_step; a zero min_step jumps straight to it
   assign cur_ext    = {cur[ValueWidth-1], cur};
   assign req_ext    = {req_clamped[ValueWidth-1], req_clamped};
   assign step_ext   = {2'b00, cfg.min_step};
   assign going_down = req_clamped < cur;
   assign moved      = going_down ? (cur_ext - step_ext) : (cur_ext + step_ext);
   assign overshoot  = going_down ? (moved < req_ext) : (moved > req_ext);

   always_comb begin
      if (cfg.min_step == '0) begin
         out_val  = req_clamped;
         step_out = state.step_active;
      end else if (overshoot) begin
         out_val  = req_clamped;
         step_out = 1'b0;
      end else begin
         out_val  = moved[ValueWidth-1:0];
         step_out = 1'b1;
      end
   end

   // next state and result per operation
   always_comb begin
      state_next = state;
      result     = '0;
      case (operation)
         OP_LOAD: begin
            state_next.requested   = set_value;
            state_next.current     = set_value;
            state_next.step_active = 1'b0;
         end
         OP_CLEAR: begin
            state_next.step_active = 1'b0;
         end
         OP_PROCESS: begin
            if (!idle_match) begin
               state_next.requested   = req_clamped;
               state_next.current     = out_val;
               state_next.step_active = step_out;
               result.processed       = 1'b1;
               result.output_value    = out_val;
               if (req_clamped != req_pre) begin
                  result.write_back       = 1'b1;
                  result.write_back_value = req_clamped;
               end
            end
         end
         default: ;
      endcase
      result.stepping = state_next.step_active;
   end

endmodule

FILE: rtl/clamped_slew_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// clamped_slew_rate_limiter_unit
// Set-point slew-rate limiter with optional clamp, one request per cycle while results are taken.
// ----------------------------------------------------------------------------
// A request is captured in an input register, evaluated combinationally (clamp,
// then a 33-bit step toward the request) and its result lands in an output
// register; one request per cycle is sustained while the result channel is
// ready. The requested/current/stepping state is updated in the same cycle a
// request leaves the input register, and that state loop sets the throughput.
// The output register decouples the sides: a new request can enter an empty
// input register while a result waits, and stays there until the result is read.
// Configuration writes take effect on the next cycle and are meant for idle.
// ----------------------------------------------------------------------------
module clamped_slew_rate_limiter_unit (
   input  logic                             clock,
   input  logic                             reset,
   csrl_req_if.sink                         req_chan,
   csrl_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [csrl_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [csrl_pkg::ValueWidth-1:0]  csr_write_data
);
   import csrl_pkg::*;

   csrl_cfg_type                 cfg;
   logic                         req_valid_ff;
   logic [OpWidth-1:0]           op_ff;
   logic signed [ValueWidth-1:0] value_ff;
   csrl_state_type               state_ff;
   csrl_state_type               state_in;
   logic                         rsp_valid_ff;
   csrl_result_type              result_ff;
   csrl_result_type              result_in;
   logic                         out_free;
   logic                         advance;

   // configuration registers
   csrl_cfg_regs u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // datapath between input and output registers
   csrl_step_logic u_step (
      .operation  (op_ff),
      .set_value  (value_ff),
      .cfg        (cfg),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // handshake: input stage moves when the output slot is free
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = req_valid_ff && out_free;
   assign req_chan.ready = !req_valid_ff || advance;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_ff    <= req_chan.operation;
         value_ff <= req_chan.set_value;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // result channel
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.processed        = result_ff.processed;
   assign rsp_chan.output_value     = result_ff.output_value;
   assign rsp_chan.stepping         = result_ff.stepping;
   assign rsp_chan.write_back       = result_ff.write_back;
   assign rsp_chan.write_back_value = result_ff.write_back_value;

endmodule

FILE: rtl/csrl_checker.sv
// ----------------------------------------------------------------------------
// csrl_checker
// Port-level checks on the limiter's result channel.
// ----------------------------------------------------------------------------
module csrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        processed,
   input logic [31:0] output_value,
   input logic        write_back,
   input logic [31:0] write_back_value
);

   // a pending result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before taken");

   // nothing comes out in the cycle after a reset cycle
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // output value is zero unless a new output was produced
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !processed |-> output_value == 32'd0)
      else $error("output value set without processing");

   // write-back only accompanies a processed request and carries zero otherwise
   a_wb_processed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && write_back |-> processed)
      else $error("write-back without processing");

   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_back |-> write_back_value == 32'd0)
      else $error("write-back value set without write-back");

endmodule

bind clamped_slew_rate_limiter_unit csrl_checker u_csrl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .processed        (rsp_chan.processed),
   .output_value     (rsp_chan.output_value),
   .write_back       (rsp_chan.write_back),
   .write_back_value (rsp_chan.write_back_value)
);
